/* rtl/aedc_pkg.sv */
// aedc_pkg: shared types, sizes and fixed-point helpers for the dense autoencoder codec.
// No dependencies; imported by aedc_front, aedc_back and autoencoder_dense_codec.
package aedc_pkg;

	localparam int NODES    = 32;
	localparam int LATENT   = 8;
	localparam int NODE_AW  = 5;
	localparam int WT_DEPTH = NODES * LATENT;
	localparam int WT_AW    = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [31:0] Q_ONE   = 32'sd65536;
	localparam logic signed [31:0] FLOOR_A = 32'sd6554;
	localparam logic signed [31:0] FLOOR_B = 32'sd13107;
	localparam logic signed [31:0] FLOOR_C = 32'sd19661;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_ENC   = 2'd1,
		KIND_DEC   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		TBL_ENC_W = 3'd0,
		TBL_DEC_W = 3'd1,
		TBL_ENC_B = 3'd2,
		TBL_DEC_B = 3'd3,
		TBL_MIN   = 3'd4,
		TBL_MAX   = 3'd5
	} tbl_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_ENC,
		OP_DEC
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [2:0]         sel;
		logic [7:0]         idx;
		logic signed [31:0] val;
	} op_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [31:0] r;
		if (x > 66'sh7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (x < -66'sh8000_0000)
			r = 32'sh8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

/* rtl/aedc_front.sv */
// aedc_front: accepts input requests, drops ignored ones and queues the rest as ops.
// Depends on aedc_pkg.
module aedc_front import aedc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [2:0]         table_select,
	input  logic [7:0]         table_index,
	input  logic signed [31:0] value,
	output logic               op_valid,
	input  logic               op_ready,
	output op_t                op
);

	op_t        q_q [QUEUE_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	op_t        cls;
	logic       push, pop;

	always_comb begin
		keep     = 1'b0;
		cls.kind = OP_WRITE;
		cls.sel  = table_select;
		cls.idx  = table_index;
		cls.val  = value;
		case (kind)
			KIND_WRITE: begin
				cls.kind = OP_WRITE;
				case (table_select)
					TBL_ENC_W, TBL_DEC_W: keep = {1'b0, table_index} < 9'(WT_DEPTH);
					TBL_ENC_B:            keep = {1'b0, table_index} < 9'(LATENT);
					TBL_DEC_B, TBL_MIN, TBL_MAX: keep = {1'b0, table_index} < 9'(NODES);
					default:              keep = 1'b0;
				endcase
			end
			KIND_ENC: begin
				cls.kind = OP_ENC;
				keep     = 1'b1;
			end
			KIND_DEC: begin
				cls.kind = OP_DEC;
				keep     = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_ready = cnt_q != 2'(QUEUE_DEPTH);
	assign push     = in_valid && in_ready && keep;
	assign op_valid = cnt_q != 2'd0;
	assign pop      = op_valid && op_ready;
	assign op       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			q_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* rtl/aedc_back.sv */
// aedc_back: table storage, vector collection, min-max mapping divider, shared MAC
// and output register. Depends on aedc_pkg.
module aedc_back import aedc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  op_t                op,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [4:0]         position,
	output logic               is_decode,
	output logic               last
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAP_RD, ST_MAP_DIV, ST_MAP_WR, ST_MAC_ADDR, ST_MAC_MUL,
		ST_MAC_ACC, ST_ROW_END, ST_DEC_MUL, ST_DEC_FIN, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MODE_IDLE, MODE_ENC, MODE_DEC
	} mode_t;

	state_t state_q;
	mode_t  mode_q;
	logic [NODE_AW-1:0] count_q;
	logic               dec_run_q;
	logic [NODE_AW-1:0] row_q, col_q;
	logic signed [55:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] t_q;
	logic signed [64:0] uprod_q;
	logic [49:0]        nq_q;
	logic [32:0]        rem_q, d_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] res_q;

	logic signed [31:0] enc_w_mem [WT_DEPTH];
	logic signed [31:0] dec_w_mem [WT_DEPTH];
	logic signed [31:0] enc_w_rd, dec_w_rd;
	logic signed [31:0] enc_b_q [LATENT];
	logic signed [31:0] dec_b_q [NODES];
	logic signed [31:0] min_q [NODES];
	logic signed [31:0] max_q [NODES];
	logic signed [31:0] buf_q [NODES];

	logic               take, wr_op, elem_op;
	logic [WT_AW-1:0]   w_addr;
	logic [NODE_AW-1:0] mm_idx;
	logic signed [31:0] lo, hi, xb, bias;
	logic signed [32:0] diff, span;
	logic [32:0]        mag;
	logic [33:0]        trial;
	logic               ge;
	logic [33:0]        new_rem;
	logic signed [51:0] qs;
	logic signed [31:0] mapped;
	logic signed [55:0] sum;
	logic signed [31:0] v, vclamp, y, yf;
	logic [NODE_AW-1:0] col_last, row_last;
	logic               emit_go;
	mode_t              op_mode;
	logic               restart;
	logic [NODE_AW-1:0] wr_pos;
	logic               run_go;

	assign op_ready = state_q == ST_IDLE;
	assign take     = op_valid && op_ready;
	assign wr_op    = take && op.kind == OP_WRITE;
	assign elem_op  = take && op.kind != OP_WRITE;
	assign op_mode  = (op.kind == OP_ENC) ? MODE_ENC : MODE_DEC;
	assign restart  = mode_q != op_mode;
	assign wr_pos   = restart ? '0 : count_q;
	assign run_go   = elem_op && (op.kind == OP_ENC ? wr_pos == NODE_AW'(NODES - 1)
	                                               : wr_pos == NODE_AW'(LATENT - 1));

	assign w_addr   = dec_run_q ? WT_AW'(int'(row_q) * LATENT + int'(col_q))
	                            : WT_AW'(int'(row_q) * NODES + int'(col_q));
	assign mm_idx   = (state_q == ST_MAP_RD || state_q == ST_MAP_WR) ? col_q : row_q;
	assign lo       = min_q[mm_idx];
	assign hi       = max_q[mm_idx];
	assign xb       = buf_q[col_q];
	assign col_last = dec_run_q ? NODE_AW'(LATENT - 1) : NODE_AW'(NODES - 1);
	assign row_last = dec_run_q ? NODE_AW'(NODES - 1) : NODE_AW'(LATENT - 1);

	always_comb begin
		diff    = 33'(xb) - 33'(lo);
		mag     = diff[32] ? 33'(-diff) : 33'(diff);
		span    = 33'(hi) - 33'(lo);
		trial   = {rem_q, nq_q[49]};
		ge      = trial >= {1'b0, d_q};
		new_rem = ge ? trial - {1'b0, d_q} : trial;
		qs      = neg_q ? -$signed({2'b00, nq_q}) : $signed({2'b00, nq_q});
		mapped  = sat32(66'(qs) - 66'(Q_ONE));
		bias    = dec_run_q ? dec_b_q[row_q] : enc_b_q[row_q[2:0]];
		sum     = acc_q + 56'(bias);
		v       = sat32(66'(sum));
		if (v <= 32'sd0)
			vclamp = 32'sd0;
		else if (v >= Q_ONE)
			vclamp = Q_ONE;
		else
			vclamp = v;
		y  = sat32(66'(uprod_q >>> 17) + 66'(lo));
		yf = y;
		if (row_q == NODE_AW'(NODES / 2) && y < FLOOR_A)
			yf = FLOOR_A;
		if (row_q == NODE_AW'(NODES / 2 + 1) && y < FLOOR_B)
			yf = FLOOR_B;
		if (row_q == NODE_AW'(NODES / 2 + 2) && y < FLOOR_C)
			yf = FLOOR_C;
	end

	assign emit_go = state_q == ST_EMIT && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (wr_op && op.sel == TBL_ENC_W)
			enc_w_mem[op.idx] <= op.val;
		enc_w_rd <= enc_w_mem[w_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_op && op.sel == TBL_DEC_W)
			dec_w_mem[op.idx] <= op.val;
		dec_w_rd <= dec_w_mem[w_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_op) begin
			case (op.sel)
				TBL_ENC_B: enc_b_q[op.idx[2:0]] <= op.val;
				TBL_DEC_B: dec_b_q[op.idx[NODE_AW-1:0]] <= op.val;
				TBL_MIN:   min_q[op.idx[NODE_AW-1:0]] <= op.val;
				TBL_MAX:   max_q[op.idx[NODE_AW-1:0]] <= op.val;
				default:   ;
			endcase
		end
		if (elem_op)
			buf_q[wr_pos] <= op.val;
		else if (state_q == ST_MAP_WR)
			buf_q[col_q] <= mapped;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MAP_RD: begin
				nq_q  <= {mag, 17'b0};
				d_q   <= span;
				neg_q <= diff[32];
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_MAP_DIV: begin
				nq_q  <= {nq_q[48:0], ge};
				rem_q <= new_rem[32:0];
				cnt_q <= cnt_q + 6'd1;
			end
			ST_MAC_MUL: prod_q <= (dec_run_q ? dec_w_rd : enc_w_rd) * xb;
			ST_ROW_END: begin
				t_q   <= sat32(66'(v) + 66'(Q_ONE));
				res_q <= vclamp;
			end
			ST_DEC_MUL: uprod_q <= 65'(t_q) * 65'(span);
			ST_DEC_FIN: res_q <= yf;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_IDLE;
			count_q      <= '0;
			dec_run_q    <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			acc_q        <= '0;
			out_valid    <= 1'b0;
			result_value <= '0;
			position     <= '0;
			is_decode    <= 1'b0;
			last         <= 1'b0;
		end else begin
			if (out_valid && out_ready && !emit_go)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (elem_op) begin
						if (run_go) begin
							mode_q    <= MODE_IDLE;
							count_q   <= '0;
							dec_run_q <= op.kind == OP_DEC;
							row_q     <= '0;
							col_q     <= '0;
							acc_q     <= '0;
							state_q   <= (op.kind == OP_DEC) ? ST_MAC_ADDR : ST_MAP_RD;
						end else begin
							mode_q  <= op_mode;
							count_q <= wr_pos + NODE_AW'(1);
						end
					end
				end
				ST_MAP_RD: begin
					if (lo < hi)
						state_q <= ST_MAP_DIV;
					else if (col_q == NODE_AW'(NODES - 1)) begin
						col_q   <= '0;
						state_q <= ST_MAC_ADDR;
					end else
						col_q <= col_q + NODE_AW'(1);
				end
				ST_MAP_DIV: begin
					if (cnt_q == 6'd49)
						state_q <= ST_MAP_WR;
				end
				ST_MAP_WR: begin
					if (col_q == NODE_AW'(NODES - 1)) begin
						col_q   <= '0;
						state_q <= ST_MAC_ADDR;
					end else begin
						col_q   <= col_q + NODE_AW'(1);
						state_q <= ST_MAP_RD;
					end
				end
				ST_MAC_ADDR: state_q <= ST_MAC_MUL;
				ST_MAC_MUL:  state_q <= ST_MAC_ACC;
				ST_MAC_ACC: begin
					acc_q <= acc_q + 56'(prod_q >>> 16);
					if (col_q == col_last) begin
						col_q   <= '0;
						state_q <= ST_ROW_END;
					end else begin
						col_q   <= col_q + NODE_AW'(1);
						state_q <= ST_MAC_ADDR;
					end
				end
				ST_ROW_END: state_q <= dec_run_q ? ST_DEC_MUL : ST_EMIT;
				ST_DEC_MUL: state_q <= ST_DEC_FIN;
				ST_DEC_FIN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						out_valid    <= 1'b1;
						result_value <= res_q;
						position     <= row_q;
						is_decode    <= dec_run_q;
						last         <= row_q == row_last;
						acc_q        <= '0;
						if (row_q == row_last)
							state_q <= ST_IDLE;
						else begin
							row_q   <= row_q + NODE_AW'(1);
							state_q <= ST_MAC_ADDR;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/autoencoder_dense_codec.sv */
// autoencoder_dense_codec: top level of the dense autoencoder codec.
// Depends on aedc_pkg, aedc_front and aedc_back.
//
// Input channel (in_valid/in_ready): each request is a table word write (kind 0)
// or one element of an encode (kind 1) or decode (kind 2) vector. Writes and
// elements are queued in a two-entry op queue; the back end drains it one op
// per cycle while idle.
// Output channel (out_valid/out_ready): result_value, position, is_decode and
// last; an encode yields 8 latent values, a decode 32 reconstructed features.
// Sequence: the final element of an encode vector starts 32 mapping steps
// (one restoring divider, one quotient bit per cycle; no divide where the
// minimum is not below the maximum), then 256 multiply-accumulates on the
// single MAC through its address, multiply and accumulate states, with row
// end and emit per output. A decode runs 8 MACs, row end, unmapping and emit per row.
// While a vector is computed the queue fills and in_ready drops.
// When the receiver stalls, the output register holds its result and the
// MAC sequence waits. Reset clears the queue, the sequencer and the output
// valid; tables and the vector buffer hold no defined value until written.
module autoencoder_dense_codec import aedc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [2:0]         table_select,
	input  logic [7:0]         table_index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [4:0]         position,
	output logic               is_decode,
	output logic               last
);

	logic op_valid, op_ready;
	op_t  op;

	aedc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.table_select (table_select),
		.table_index  (table_index),
		.value        (value),
		.op_valid     (op_valid),
		.op_ready     (op_ready),
		.op           (op)
	);

	aedc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op_ready     (op_ready),
		.op           (op),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.position     (position),
		.is_decode    (is_decode),
		.last         (last)
	);

endmodule

/* dv/testbench.sv */
// Self-checking testbench for autoencoder_dense_codec: loads every table, drives
// directed and random table writes and encode/decode vectors, and checks each result.
// Depends on rtl/aedc_pkg.sv and rtl/autoencoder_dense_codec.sv.
`timescale 1ns / 1ps

module testbench;
	import aedc_pkg::*;

	localparam int  LIMIT   = 1000000;
	localparam int  DRAIN   = 3000;
	localparam logic [2:0] TBL_SPARE_LO = 3'd6;
	localparam logic [2:0] TBL_SPARE_HI = 3'd7;

	typedef struct {
		logic [1:0]         kind;
		logic [2:0]         sel;
		logic [7:0]         idx;
		logic signed [31:0] val;
	} req_t;

	typedef struct {
		logic signed [31:0] val;
		logic [4:0]         pos;
		logic               dec;
		logic               last;
	} res_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid, in_ready, out_valid, out_ready;
	logic [1:0]         kind;
	logic [2:0]         table_select;
	logic [7:0]         table_index;
	logic signed [31:0] value, result_value;
	logic [4:0]         position;
	logic               is_decode, last;

	req_t pending_reqs[$];
	res_t expected_results[$];
	int   errors = 0, accepted = 0, total_reqs = 0, cycles = 0;
	int   phase = 0;

	// local copy of the block's state
	logic signed [31:0] enc_w[WT_DEPTH], dec_w[WT_DEPTH];
	logic signed [31:0] enc_b[LATENT], dec_b[NODES], fmin[NODES], fmax[NODES];
	logic signed [31:0] vec_buf[NODES];
	int                 elem_cnt = 0;
	logic [1:0]         cur_mode = KIND_WRITE;

	always #5 clk = ~clk;

	autoencoder_dense_codec DUT (.*);

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint div_floor(longint x, longint d);
		if (x >= 0) return x / d;
		return -((-x + d - 1) / d);
	endfunction

	task automatic run_encoder();
		longint x[NODES];
		longint acc, v, lo, hi;
		for (int i = 0; i < NODES; i++) begin
			lo = fmin[i];
			hi = fmax[i];
			x[i] = vec_buf[i];
			if (lo < hi)
				x[i] = clip32(((x[i] - lo) * 131072) / (hi - lo) - 65536);
		end
		for (int r = 0; r < LATENT; r++) begin
			acc = 0;
			for (int i = 0; i < NODES; i++)
				acc += div_floor(longint'(enc_w[r*NODES+i]) * x[i], 65536);
			v = clip32(acc + enc_b[r]);
			if (v <= 0) v = 0;
			if (v >= 65536) v = 65536;
			expected_results.push_back('{32'(v), 5'(r), 1'b0, r == LATENT-1});
		end
	endtask

	task automatic run_decoder();
		longint acc, v, t, span;
		for (int r = 0; r < NODES; r++) begin
			acc = 0;
			for (int c = 0; c < LATENT; c++)
				acc += div_floor(longint'(dec_w[r*LATENT+c]) * vec_buf[c], 65536);
			v = clip32(acc + dec_b[r]);
			t = clip32(v + 65536);
			span = longint'(fmax[r]) - fmin[r];
			v = clip32(div_floor(t * span, 131072) + fmin[r]);
			if (r == NODES/2   && v < FLOOR_A) v = FLOOR_A;
			if (r == NODES/2+1 && v < FLOOR_B) v = FLOOR_B;
			if (r == NODES/2+2 && v < FLOOR_C) v = FLOOR_C;
			expected_results.push_back('{32'(v), 5'(r), 1'b1, r == NODES-1});
		end
	endtask

	task automatic apply_request(req_t q);
		int need;
		if (q.kind == KIND_WRITE) begin
			case (q.sel)
				TBL_ENC_W: if (q.idx < WT_DEPTH) enc_w[q.idx] = q.val;
				TBL_DEC_W: if (q.idx < WT_DEPTH) dec_w[q.idx] = q.val;
				TBL_ENC_B: if (q.idx < LATENT) enc_b[q.idx] = q.val;
				TBL_DEC_B: if (q.idx < NODES) dec_b[q.idx] = q.val;
				TBL_MIN:   if (q.idx < NODES) fmin[q.idx] = q.val;
				TBL_MAX:   if (q.idx < NODES) fmax[q.idx] = q.val;
				default: ;
			endcase
			return;
		end
		if (q.kind == KIND_NONE) return;
		if (cur_mode != q.kind) begin
			cur_mode = q.kind;
			elem_cnt = 0;
		end
		need = (q.kind == KIND_ENC) ? NODES : LATENT;
		vec_buf[elem_cnt] = q.val;
		elem_cnt++;
		if (elem_cnt < need) return;
		elem_cnt = 0;
		cur_mode = KIND_WRITE;
		if (q.kind == KIND_ENC) run_encoder();
		else run_decoder();
	endtask

	task automatic add_write(logic [2:0] sel, int idx, logic signed [31:0] v);
		pending_reqs.push_back('{KIND_WRITE, sel, 8'(idx), v});
	endtask

	task automatic add_elem(logic [1:0] k, logic signed [31:0] v);
		pending_reqs.push_back('{k, 3'($urandom_range(7)), 8'($urandom), v});
	endtask

	function automatic logic signed [31:0] pick_data();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(262143)) - 131072;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_weight();
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(65535)) - 32768;
	endfunction

	task automatic load_minmax(int i);
		logic signed [31:0] lo;
		lo = -$signed($urandom_range(1 << 20));
		add_write(TBL_MIN, i, lo);
		add_write(TBL_MAX, i, lo + $signed($urandom_range(1 << 21)) + 1);
	endtask

	task automatic add_vector(logic [1:0] k, int n, bit mix_writes);
		for (int i = 0; i < n; i++) begin
			if (mix_writes && $urandom_range(9) == 0)
				add_write(3'($urandom_range(5)), $urandom_range(7), pick_weight());
			add_elem(k, pick_data());
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		req_t q;
		int   gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_WRITE;
			table_select <= TBL_ENC_W;
			table_index <= '0;
			value <= '0;
		end else begin
			if (in_valid && in_ready) begin
				apply_request('{kind, table_select, table_index, value});
				accepted++;
				phase <= (accepted * 3 < total_reqs) ? 0 : (accepted * 3 < total_reqs * 2) ? 1 : 2;
			end
			if (!in_valid || in_ready) begin
				gap = (phase == 0) ? 19 : (phase == 1) ? 84 : 0;
				if (pending_reqs.size() > 0 && $urandom_range(99) >= gap) begin
					q = pending_reqs.pop_front();
					in_valid <= 1'b1;
					kind <= q.kind;
					table_select <= q.sel;
					table_index <= q.idx;
					value <= q.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		int   stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result value=%0d position=%0d", result_value, position);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (result_value !== e.val) begin
						$error("result_value: expected %0d, got %0d", e.val, result_value);
						errors++;
					end
					if (position !== e.pos) begin
						$error("position: expected %0d, got %0d", e.pos, position);
						errors++;
					end
					if (is_decode !== e.dec) begin
						$error("is_decode: expected %0d, got %0d", e.dec, is_decode);
						errors++;
					end
					if (last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, last);
						errors++;
					end
				end
			end
			stall = (phase == 0) ? 84 : (phase == 1) ? 19 : 0;
			out_ready <= ($urandom_range(99) >= stall);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int n;
		// full table load
		for (int i = 0; i < WT_DEPTH; i++) add_write(TBL_ENC_W, i, pick_weight());
		for (int i = 0; i < WT_DEPTH; i++) add_write(TBL_DEC_W, i, pick_weight());
		for (int i = 0; i < LATENT; i++) add_write(TBL_ENC_B, i, pick_weight());
		for (int i = 0; i < NODES; i++) add_write(TBL_DEC_B, i, pick_weight());
		for (int i = 0; i < NODES; i++) load_minmax(i);
		// degenerate ranges and full span
		add_write(TBL_MIN, 3, 32'sd1000);
		add_write(TBL_MAX, 3, 32'sd1000);
		add_write(TBL_MIN, 5, 32'sd5000);
		add_write(TBL_MAX, 5, -32'sd5000);
		add_write(TBL_MIN, 7, 32'sh8000_0000);
		add_write(TBL_MAX, 7, 32'sh7FFF_FFFF);
		add_write(TBL_ENC_W, 255, 32'sh7FFF_FFFF);
		add_write(TBL_DEC_W, 0, 32'sh8000_0000);
		// writes that must be dropped
		add_write(TBL_ENC_B, 8, 32'sh7FFF_FFFF);
		add_write(TBL_ENC_B, 255, 32'sh8000_0000);
		add_write(TBL_DEC_B, 32, 32'sh7FFF_FFFF);
		add_write(TBL_MIN, 200, '1);
		add_write(TBL_SPARE_LO, 0, '1);
		add_write(TBL_SPARE_HI, 255, '1);
		pending_reqs.push_back('{KIND_NONE, 3'd7, 8'hFF, 32'sh7FFF_FFFF});
		// extreme elements
		for (int i = 0; i < NODES; i++)
			add_elem(KIND_ENC, i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000);
		for (int i = 0; i < LATENT; i++)
			add_elem(KIND_DEC, i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
		// mode switch, then a write in the middle of a vector
		add_vector(KIND_ENC, 5, 0);
		add_vector(KIND_DEC, 3, 0);
		add_write(TBL_DEC_B, 16, -32'sd200000);
		pending_reqs.push_back('{KIND_NONE, 3'd0, 8'd0, 32'sd0});
		add_vector(KIND_DEC, 5, 0);
		add_vector(KIND_ENC, 32, 1);

		n = 0;
		while (n < 400) begin
			int sz, r;
			sz = pending_reqs.size();
			r = $urandom_range(99);
			if (r < 35) add_vector(KIND_ENC, NODES, 1);
			else if (r < 65) add_vector(KIND_DEC, LATENT, 1);
			else if (r < 85) begin
				repeat ($urandom_range(4, 1)) begin
					case ($urandom_range(7))
						0: add_write(3'($urandom_range(7)), $urandom_range(255), $urandom);
						1: pending_reqs.push_back('{KIND_NONE, 3'($urandom),
						                            8'($urandom), $urandom});
						2: load_minmax($urandom_range(NODES - 1));
						default: add_write(3'($urandom_range(5)), $urandom_range(7),
						                   pick_weight());
					endcase
				end
			end else begin
				add_vector($urandom_range(1) ? KIND_ENC : KIND_DEC, $urandom_range(6, 1), 0);
			end
			n += pending_reqs.size() - sz;
		end
		total_reqs = pending_reqs.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && accepted == total_reqs);
		wait (expected_results.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/aedc_pkg.sv
rtl/aedc_front.sv
rtl/aedc_back.sv
rtl/autoencoder_dense_codec.sv
dv/testbench.sv
